>>> design/atan2_rational_approx_defines.svh
// assertion helpers for the atan2 pipeline
`ifndef ATAN2_RATIONAL_APPROX_DEFINES_SVH
`define ATAN2_RATIONAL_APPROX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ATAN2RA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atan2ra check failed");

// next-cycle implication
`define ATAN2RA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atan2ra check failed");

`endif

>>> design/atan2ra_pkg.sv
// ----------------------------------------------------------------------------
// atan2ra_pkg
// shared types and constants of the rational atan2 pipeline
// ----------------------------------------------------------------------------
package atan2ra_pkg;

	// pi in unsigned q4.60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef struct packed {
		logic x_zero;
		logic x_neg;
		logic y_neg;
		logic y_zero;
		logic y_lt_x;
	} flags_t;

endpackage

>>> design/atan2_rational_approx.sv
// ----------------------------------------------------------------------------
// atan2_rational_approx
// four-quadrant atan2 by the 0.28 rational approximation, fully pipelined
// ----------------------------------------------------------------------------
// Takes one coordinate pair per cycle and returns the angle in signed
// fixed point with ANGLE_FRAC_BITS fraction bits, ANGLE_FRAC_BITS + 3 bits
// wide. The pipeline has three stages of magnitudes and products, one
// restoring division stage per quotient bit (ANGLE_FRAC_BITS + 1 of them),
// and one rounding and quadrant stage. The whole pipeline holds while a
// result waits on out_stall; otherwise it accepts an item every cycle.
// ----------------------------------------------------------------------------
`include "atan2_rational_approx_defines.svh"

module atan2_rational_approx #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COORD_WIDTH-1:0]       coord_y,
	input  logic [COORD_WIDTH-1:0]       coord_x,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ANGLE_FRAC_BITS+2:0]   angle
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = ANGLE_FRAC_BITS;
	localparam int DW = 2 * W + 4;
	localparam int QW = F + 1;
	localparam int NS = F + 1;

	logic                en;
	logic                dv    [0:NS];
	logic [DW-1:0]       drem  [0:NS];
	logic [DW-1:0]       dden  [0:NS];
	logic [QW-1:0]       dquo  [0:NS];
	atan2ra_pkg::flags_t dflg  [0:NS];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign dquo[0]  = '0;

	atan2ra_front #(.W(W), .DW(DW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.coord_y  (coord_y),
		.coord_x  (coord_x),
		.valid_s3 (dv[0]),
		.num_s3   (drem[0]),
		.den_s3   (dden[0]),
		.flags_s3 (dflg[0])
	);

	for (genvar i = 0; i < NS; i++) begin : g_div
		atan2ra_div_stage #(.DW(DW), .QW(QW)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (dv[i]),
			.rem_in    (drem[i]),
			.den_in    (dden[i]),
			.quo_in    (dquo[i]),
			.flags_in  (dflg[i]),
			.valid_out (dv[i+1]),
			.rem_out   (drem[i+1]),
			.den_out   (dden[i+1]),
			.quo_out   (dquo[i+1]),
			.flags_out (dflg[i+1])
		);
	end

	atan2ra_back #(.F(F)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (dv[NS]),
		.quo_in    (dquo[NS]),
		.flags_in  (dflg[NS]),
		.out_valid (out_valid),
		.angle     (angle)
	);

	`ATAN2RA_ASSERT_NOW(a_stall_only_on_held_result, in_stall, out_valid && out_stall)
	`ATAN2RA_ASSERT_NEXT(a_last_div_feeds_output, en && dv[NS], out_valid)
	`ATAN2RA_ASSERT_NOW(a_xzero_core_skipped, dv[NS] && dflg[NS].x_zero && dflg[NS].y_zero,
		!dflg[NS].y_lt_x)

endmodule

>>> design/atan2ra_front.sv
// ----------------------------------------------------------------------------
// atan2ra_front
// magnitudes, products and the numerator / denominator of the core term
// ----------------------------------------------------------------------------
module atan2ra_front #(
	parameter int W  = 16,
	parameter int DW = 2 * W + 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [W-1:0]         coord_y,
	input  logic [W-1:0]         coord_x,
	output logic                 valid_s3,
	output logic [DW-1:0]        num_s3,
	output logic [DW-1:0]        den_s3,
	output atan2ra_pkg::flags_t  flags_s3
);

	logic                valid_s1, valid_s2;
	logic [W-1:0]        mx_s1, mn_s1;
	atan2ra_pkg::flags_t flags_s1, flags_s2;
	logic [2*W-1:0]      ab_s2, mx2_s2, mn2_s2;
	logic [W-1:0]        ax, by;
	logic                y_lt_x;
	logic [DW-1:0]       ab_e, mx2_e, mn2_e;

	assign ax     = coord_x[W-1] ? (~coord_x + W'(1)) : coord_x;
	assign by     = coord_y[W-1] ? (~coord_y + W'(1)) : coord_y;
	assign y_lt_x = by < ax;

	assign ab_e  = DW'(ab_s2);
	assign mx2_e = DW'(mx2_s2);
	assign mn2_e = DW'(mn2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1           <= y_lt_x ? ax : by;
			mn_s1           <= y_lt_x ? by : ax;
			flags_s1.x_zero <= (coord_x == '0);
			flags_s1.x_neg  <= coord_x[W-1];
			flags_s1.y_neg  <= coord_y[W-1];
			flags_s1.y_zero <= (coord_y == '0);
			flags_s1.y_lt_x <= y_lt_x;

			ab_s2    <= (2*W)'(mx_s1) * (2*W)'(mn_s1);
			mx2_s2   <= (2*W)'(mx_s1) * (2*W)'(mx_s1);
			mn2_s2   <= (2*W)'(mn_s1) * (2*W)'(mn_s1);
			flags_s2 <= flags_s1;

			// 25 = 16 + 8 + 1, 7 = 8 - 1
			num_s3   <= (ab_e << 4) + (ab_e << 3) + ab_e;
			den_s3   <= (mx2_e << 4) + (mx2_e << 3) + mx2_e + (mn2_e << 3) - mn2_e;
			flags_s3 <= flags_s2;
		end
	end

endmodule

>>> design/atan2ra_div_stage.sv
// ----------------------------------------------------------------------------
// atan2ra_div_stage
// one restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
module atan2ra_div_stage #(
	parameter int DW = 36,
	parameter int QW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [DW-1:0]        rem_in,
	input  logic [DW-1:0]        den_in,
	input  logic [QW-1:0]        quo_in,
	input  atan2ra_pkg::flags_t  flags_in,
	output logic                 valid_out,
	output logic [DW-1:0]        rem_out,
	output logic [DW-1:0]        den_out,
	output logic [QW-1:0]        quo_out,
	output atan2ra_pkg::flags_t  flags_out
);

	logic [DW:0] r2, diff;
	logic        ge;

	assign r2   = {rem_in, 1'b0};
	assign diff = r2 - {1'b0, den_in};
	assign ge   = r2 >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out   <= ge ? diff[DW-1:0] : r2[DW-1:0];
			den_out   <= den_in;
			quo_out   <= {quo_in[QW-2:0], ge};
			flags_out <= flags_in;
		end
	end

endmodule

>>> design/atan2ra_back.sv
// ----------------------------------------------------------------------------
// atan2ra_back
// rounding, sign and quadrant correction into the output register
// ----------------------------------------------------------------------------
module atan2ra_back #(
	parameter int F = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [F:0]           quo_in,
	input  atan2ra_pkg::flags_t  flags_in,
	output logic                 out_valid,
	output logic [F+2:0]         angle
);

	localparam logic [63:0] PI_FULL =
		(atan2ra_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
	localparam logic [63:0] HPI_FULL =
		(atan2ra_pkg::PI_Q60 + (64'd1 << (60 - F))) >> (61 - F);
	localparam logic signed [F+3:0] PI  = PI_FULL[F+3:0];
	localparam logic signed [F+3:0] HPI = HPI_FULL[F+3:0];

	logic [F+1:0]          q_inc;
	logic signed [F+3:0]   t_mag, t, ang;

	assign q_inc = {1'b0, quo_in} + (F+2)'(1);
	assign t_mag = signed'((F+4)'(q_inc[F+1:1]));
	assign t     = (flags_in.x_neg != flags_in.y_neg) ? -t_mag : t_mag;

	always_comb begin
		if (flags_in.x_zero) begin
			ang = flags_in.y_zero ? '0 : (flags_in.y_neg ? -HPI : HPI);
		end else if (flags_in.y_lt_x) begin
			ang = t;
			if (flags_in.x_neg) begin
				ang = flags_in.y_neg ? t - PI : t + PI;
			end
		end else begin
			ang = HPI - t;
			if (flags_in.y_neg) begin
				ang = HPI - t - PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= ang[F+2:0];
		end
	end

endmodule

>>> tb/sv/atan2_rational_approx_tb.sv
// ----------------------------------------------------------------------------
// atan2_rational_approx_tb
// self-checking bench for the rational atan2 pipeline
// ----------------------------------------------------------------------------
// Feeds coordinate pairs through the valid/stall channels with random gaps on
// both sides, predicts each angle by exact long division of the 0.28 rational
// form, and compares results in order. Corner pairs come first, then random
// pairs biased toward axes, diagonals and extreme magnitudes.
// ----------------------------------------------------------------------------
module atan2_rational_approx_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int FB = 13;
	localparam int AW = FB + 3;
	localparam int LATENCY = FB + 5;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1250;

	class angle_scoreboard;
		logic [AW-1:0] pending_angles[$];
		int mismatches;
		int report_count;

		function logic [63:0] round_pi(int shift);
			logic [63:0] p;
			p = atan2ra_pkg::PI_Q60 + (64'd1 << (shift - 1));
			return p >> shift;
		endfunction

		function logic [AW-1:0] predict_angle(logic [CW-1:0] yv, logic [CW-1:0] xv);
			longint y, x, a, b, pi_q, half_pi, t, ang;
			logic [127:0] num, den, rem;
			longint q;
			bit is_small;
			y = $signed(yv);
			x = $signed(xv);
			pi_q = round_pi(60 - FB);
			half_pi = round_pi(61 - FB);
			a = x < 0 ? -x : x;
			b = y < 0 ? -y : y;
			if (x == 0) begin
				ang = y > 0 ? half_pi : (y < 0 ? -half_pi : 0);
			end else begin
				is_small = b < a;
				num = 128'(a * b) * 25;
				if (is_small)
					den = 128'(a * a) * 25 + 128'(b * b) * 7;
				else
					den = 128'(b * b) * 25 + 128'(a * a) * 7;
				rem = num;
				q = 0;
				for (int i = 0; i < FB + 1; i++) begin
					rem = rem << 1;
					q = q << 1;
					if (rem >= den) begin
						rem = rem - den;
						q = q | 1;
					end
				end
				t = (q + 1) >>> 1;
				if ((x < 0) != (y < 0))
					t = -t;
				if (is_small) begin
					ang = t;
					if (x < 0)
						ang += (y < 0) ? -pi_q : pi_q;
				end else begin
					ang = half_pi - t;
					if (y < 0)
						ang -= pi_q;
				end
			end
			return ang[AW-1:0];
		endfunction

		function void note_input(logic [CW-1:0] yv, logic [CW-1:0] xv);
			pending_angles.push_back(predict_angle(yv, xv));
		endfunction

		function void check_angle(logic [AW-1:0] got);
			logic [AW-1:0] exp_angle;
			if (pending_angles.size() == 0) begin
				mismatches++;
				if (report_count < 10) begin
					report_count++;
					$display("unexpected angle %0d", $signed(got));
				end
				return;
			end
			exp_angle = pending_angles.pop_front();
			if (got !== exp_angle) begin
				mismatches++;
				if (report_count < 10) begin
					report_count++;
					$display("angle mismatch: expected %0d actual %0d",
						$signed(exp_angle), $signed(got));
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [CW-1:0] coord_y = '0;
	logic [CW-1:0] coord_x = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [AW-1:0] angle;

	angle_scoreboard angles = new();
	bit hold_off_active = 0;
	bit stimulus_done = 0;
	int idle_cycles = 0;

	atan2_rational_approx #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_y(coord_y), .coord_x(coord_x),
		.out_valid(out_valid), .out_stall(out_stall),
		.angle(angle)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic logic [CW-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3: return CW'($signed($urandom_range(0, 8)) - 4);
			default: return CW'($urandom());
		endcase
	endfunction

	// offer one item and hold it until accepted
	task automatic offer_pair(logic [CW-1:0] yv, logic [CW-1:0] xv);
		in_valid <= 1;
		coord_y <= yv;
		coord_x <= xv;
		do @(posedge clk); while (in_stall);
		angles.note_input(yv, xv);
	endtask

	task automatic send_pair(logic [CW-1:0] yv, logic [CW-1:0] xv);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		offer_pair(yv, xv);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (angles.pending_angles.size() != 0)
			@(posedge clk);
	endtask

	// input side
	initial begin
		logic [CW-1:0] yv, xv;
		logic [CW-1:0] corners[8];
		corners = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h8001,
			16'h0100, 16'hff00};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_pair(16'h0005, 16'h0000);
		send_pair(16'hfffb, 16'h0000);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h0000, 16'hfff0);
		send_pair(16'h0000, 16'h0010);
		send_pair(16'h0007, 16'h0007);
		send_pair(16'hfff9, 16'h0007);
		send_pair(16'h0007, 16'hfff9);
		send_pair(16'hfff9, 16'hfff9);
		send_pair(16'h8000, 16'h8000);
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'h7fff, 16'h7fff);
		send_pair(16'h0001, 16'h8000);
		send_pair(16'hffff, 16'h8000);
		send_pair(16'h8000, 16'h0001);
		send_pair(16'hffff, 16'h7fff);
		send_pair(16'h7fff, 16'h0000);
		send_pair(16'h8000, 16'h0000);
		send_pair(16'h5555, 16'haaaa);
		wait_drained();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				hold_off_active = 1;
			if (n == 700)
				wait_drained();
			if (n >= 300 && n < 340) begin
				yv = CW'($urandom());
				xv = CW'($urandom());
				offer_pair(yv, xv);
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						yv = corners[$urandom_range(0, 7)];
						xv = corners[$urandom_range(0, 7)];
					end
					1: begin xv = pick_coord(); yv = $urandom_range(0, 1) ? xv : -xv; end
					2: begin yv = pick_coord(); xv = '0; end
					3: begin xv = pick_coord(); yv = '0; end
					default: begin yv = pick_coord(); xv = pick_coord(); end
				endcase
				send_pair(yv, xv);
			end
		end
		in_valid <= 0;
		stimulus_done = 1;
	end

	// output side
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off_active) begin
				out_stall <= 1;
				repeat (80) @(posedge clk);
				hold_off_active = 0;
			end
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			angles.check_angle(angle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stimulus_done);
		while (angles.pending_angles.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
		end else begin
			repeat (LATENCY * 3) @(posedge clk);
			if (angles.mismatches == 0 && angles.pending_angles.size() == 0)
				$display("No mismatches found");
			else
				$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end
endmodule
